// ----- rtl/xri_pkg.sv -----
// ----------------------------------------------------------------------------
// xri_pkg
// Shared types, constants and the xorshift step for the ranged generator.
// ----------------------------------------------------------------------------
package xri_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int CFG_IDX_W = 2;
  localparam int Q_DEPTH   = 2;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 6;

  localparam logic [DATA_W-1:0] SEED_RESET = DATA_W'(42);

  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = CFG_IDX_W'(2);

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  we;
    word_t value;
  } seed_wr_t;

  typedef struct packed {
    word_t lower;
    word_t span;
  } range_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic word_t advance(input word_t x);
    word_t y;
    y = x ^ (x << SHIFT_A);
    y = y ^ (y >> SHIFT_B);
    y = y ^ (y << SHIFT_C);
    return y;
  endfunction

endpackage

// ----- rtl/xri_front.sv -----
// ----------------------------------------------------------------------------
// xri_front
// Accepts items, advances the generator state on each request and queues it.
// ----------------------------------------------------------------------------
module xri_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_request,
  input  xri_pkg::seed_wr_t seed_wr,
  input  xri_pkg::q_stat_t q_stat,
  output logic             q_push,
  output xri_pkg::word_t   q_data
);

  xri_pkg::word_t state_r;
  xri_pkg::word_t state_nxt;
  xri_pkg::word_t stepped;
  logic           take;

  assign in_stall = q_stat.full;
  assign take     = in_valid && !q_stat.full;
  assign stepped  = xri_pkg::advance(state_r);
  assign q_push   = take && in_request;
  assign q_data   = stepped;

  always_comb begin
    state_nxt = state_r;
    if (seed_wr.we) begin
      state_nxt = seed_wr.value;
    end else if (q_push) begin
      state_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xri_pkg::SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/xri_fifo.sv -----
// ----------------------------------------------------------------------------
// xri_fifo
// Short queue of advanced generator states between front and back.
// ----------------------------------------------------------------------------
module xri_fifo #(
  parameter int DEPTH = xri_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xri_pkg::word_t   wr_data,
  input  logic             pop,
  output xri_pkg::word_t   rd_data,
  output xri_pkg::q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xri_pkg::word_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/xri_back.sv -----
// ----------------------------------------------------------------------------
// xri_back
// Reduces a queued state into the range with a restoring remainder unit.
// ----------------------------------------------------------------------------
module xri_back (
  input  logic             clk,
  input  logic             rst_n,
  input  xri_pkg::range_t  range,
  input  xri_pkg::q_stat_t q_stat,
  input  xri_pkg::word_t   q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic signed [xri_pkg::DATA_W-1:0] out_value
);

  localparam int W = xri_pkg::DATA_W;
  localparam logic [xri_pkg::CNT_W-1:0] CNT_LAST = xri_pkg::CNT_W'(W - 1);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    HOLD
  } state_t;

  state_t                    state_r, state_nxt;
  logic [xri_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  xri_pkg::word_t            rem_r, rem_nxt;
  xri_pkg::word_t            div_r, div_nxt;
  logic                      out_valid_r, out_valid_nxt;
  xri_pkg::word_t            out_value_r, out_value_nxt;
  logic [W:0]                trial;
  logic [W:0]                diff;
  logic                      slot_free;

  assign trial     = {rem_r, div_r[W-1]};
  assign diff      = trial - {1'b0, range.span};
  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    case (state_r)
      IDLE: begin
        if (!q_stat.empty) begin
          cnt_nxt = '0;
          div_nxt = q_data;
          if (range.span == '0) begin
            rem_nxt   = q_data;
            state_nxt = HOLD;
          end else begin
            rem_nxt   = '0;
            state_nxt = RUN;
          end
        end
      end
      RUN: begin
        rem_nxt = diff[W] ? trial[W-1:0] : diff[W-1:0];
        div_nxt = {div_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + xri_pkg::CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = HOLD;
        end
      end
      HOLD: begin
        if (slot_free) begin
          out_value_nxt = range.lower + rem_r;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    out_value_r <= out_value_nxt;
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == IDLE) && !q_stat.empty)
    else $error("Queue popped outside the idle state.");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RUN) && (cnt_r == CNT_LAST) |=> (state_r == HOLD))
    else $error("Remainder pass did not end after the last bit.");

  a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == HOLD) && slot_free |=> out_valid_r && (state_r == IDLE))
    else $error("Finished item was not moved to the output register.");

endmodule

// ----- rtl/xorshift_ranged_integer.sv -----
// ----------------------------------------------------------------------------
// xorshift_ranged_integer
// Ranged 32-bit xorshift random integer generator.
// ----------------------------------------------------------------------------
// Each accepted item with request set advances a 13/17/6 xorshift state in
// the front end and queues it; items with request clear are accepted and
// give no result. The back end maps the state to the low bound plus the
// state modulo (high bound - low bound + 1), using a restoring remainder
// unit that resolves one bit per cycle: it fetches a state from the queue,
// runs 32 remainder steps and then loads the output register once that is
// free. A span of zero, the full 32-bit range, skips the remainder steps.
// A queue of Q_DEPTH states lets requests be taken while the back end
// works, and a result waiting in the output register does not hold up the
// next computation. Writing the REG_SEED register also reloads the state.
module xorshift_ranged_integer #(
  parameter int Q_DEPTH = xri_pkg::Q_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_request,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [xri_pkg::DATA_W-1:0]   out_value,
  input  logic                                cfg_we,
  input  logic [xri_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [xri_pkg::DATA_W-1:0]          cfg_wdata
);

  xri_pkg::word_t    lower_r, lower_nxt;
  xri_pkg::word_t    upper_r, upper_nxt;
  xri_pkg::seed_wr_t seed_wr;
  xri_pkg::range_t   range;
  xri_pkg::q_stat_t  q_stat;
  xri_pkg::word_t    q_wr_data;
  xri_pkg::word_t    q_rd_data;
  logic              q_push;
  logic              q_pop;

  assign seed_wr.we    = cfg_we && (cfg_index == xri_pkg::REG_SEED);
  assign seed_wr.value = cfg_wdata;
  assign range.lower   = lower_r;
  assign range.span    = upper_r - lower_r + xri_pkg::DATA_W'(1);

  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    if (cfg_we && (cfg_index == xri_pkg::REG_LOWER)) begin
      lower_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == xri_pkg::REG_UPPER)) begin
      upper_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  xri_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_request (in_request),
    .seed_wr    (seed_wr),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  xri_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  xri_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .range     (range),
    .q_stat    (q_stat),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

endmodule
